// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, disabled while reset is asserted
`define AST_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that runs also during reset
`define AST_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rslw_pkg.sv =====
// types, constants and the microcode program of the row stepped line walker
// no dependencies
package rslw_pkg;

	localparam int CW = 5;
	localparam int DIV_CNT_W = $clog2(CW + 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CW - 1);

	typedef struct packed {
		logic [CW-1:0] start_col;
		logic [CW-1:0] start_row;
		logic [CW-1:0] end_col;
		logic [CW-1:0] end_row;
	} in_item_t;

	typedef struct packed {
		logic [CW-1:0] point_col;
		logic [CW-1:0] point_row;
		logic          last_point;
	} out_item_t;

	typedef logic [1:0] upc_t;

	localparam upc_t UPC_IDLE  = 2'd0;
	localparam upc_t UPC_CHECK = 2'd1;
	localparam upc_t UPC_DIV   = 2'd2;
	localparam upc_t UPC_EMIT  = 2'd3;

	typedef enum logic [1:0] {
		COND_NOT_START,
		COND_ADY_ZERO,
		COND_DIV_BUSY,
		COND_NOT_LAST
	} cond_t;

	typedef struct packed {
		logic  ld;
		logic  div;
		logic  emit;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic ady_zero;
		logic div_busy;
		logic not_last;
	} stat_t;

	// jump to target when cond holds, otherwise fall through to next step
	function automatic ctrl_t ucode(input upc_t pc);
		ctrl_t cw;
		cw = '{ld: 1'b0, div: 1'b0, emit: 1'b0, cond: COND_NOT_START, target: UPC_IDLE};
		case (pc)
			UPC_IDLE: begin
				cw.ld     = 1'b1;
				cw.cond   = COND_NOT_START;
				cw.target = UPC_IDLE;
			end
			UPC_CHECK: begin
				cw.cond   = COND_ADY_ZERO;
				cw.target = UPC_IDLE;
			end
			UPC_DIV: begin
				cw.div    = 1'b1;
				cw.cond   = COND_DIV_BUSY;
				cw.target = UPC_DIV;
			end
			UPC_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = COND_NOT_LAST;
				cw.target = UPC_EMIT;
			end
			default: begin
				cw.cond   = COND_NOT_START;
				cw.target = UPC_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hw/rtl/rslw_seq.sv =====
// microcode sequencer: step counter, control rom lookup and jump logic
// depends on rslw_pkg
module rslw_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  rslw_pkg::stat_t stat,
	output rslw_pkg::ctrl_t ctrl,
	output logic            busy
);

	rslw_pkg::upc_t pc_q;
	rslw_pkg::upc_t pc_next;
	logic           take;

	assign ctrl = rslw_pkg::ucode(pc_q);
	assign busy = (pc_q != rslw_pkg::UPC_IDLE);

	always_comb begin
		case (ctrl.cond)
			rslw_pkg::COND_NOT_START: take = !stat.start;
			rslw_pkg::COND_ADY_ZERO:  take = stat.ady_zero;
			rslw_pkg::COND_DIV_BUSY:  take = stat.div_busy;
			rslw_pkg::COND_NOT_LAST:  take = stat.not_last;
			default:                  take = 1'b0;
		endcase
		// last step wraps to idle on fall through
		pc_next = take ? ctrl.target : pc_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rslw_pkg::UPC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== hw/rtl/rslw_datapath.sv =====
// datapath: operand load and clamp, serial divider, incremental column stepper
// depends on rslw_pkg
module rslw_datapath #(
	parameter int GRID_SIZE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rslw_pkg::ctrl_t     ctrl,
	input  rslw_pkg::in_item_t  item,
	output logic                ady_zero,
	output logic                div_busy,
	output logic                not_last,
	output logic                result_valid,
	output rslw_pkg::out_item_t result
);

	localparam int CW = rslw_pkg::CW;
	localparam int LIM_I = (GRID_SIZE - 1 < 31) ? GRID_SIZE - 1 : 31;
	localparam logic [CW-1:0] LIM = CW'(LIM_I);

	logic [CW-1:0] sc, sr, ec, er;
	logic [CW-1:0] sc_q, row_q, ady_q, dvd_q, rem_q, q_q, r_q, cnt_q;
	logic          up_q, neg_q;
	logic [rslw_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [CW:0]   trial, r_sum, q_sum;
	logic          trial_ge, wrap;
	logic [CW-1:0] col_off, point_col;
	logic          result_valid_q;
	rslw_pkg::out_item_t result_q;

	always_comb begin
		sc = (item.start_col > LIM) ? LIM : item.start_col;
		sr = (item.start_row > LIM) ? LIM : item.start_row;
		ec = (item.end_col   > LIM) ? LIM : item.end_col;
		er = (item.end_row   > LIM) ? LIM : item.end_row;
	end

	// restoring divide step: adx = qa*ady + b
	assign trial    = {rem_q, dvd_q[CW-1]};
	assign trial_ge = (trial >= {1'b0, ady_q});

	// per-row step: q += qa (+1 on carry), r += b mod ady
	assign r_sum = {1'b0, r_q} + {1'b0, rem_q};
	assign wrap  = (r_sum >= {1'b0, ady_q});
	assign q_sum = {1'b0, q_q} + {1'b0, dvd_q} + {{CW{1'b0}}, wrap};

	// ceil for leftward lines
	assign col_off   = q_q + {{(CW-1){1'b0}}, (neg_q && (r_q != '0))};
	assign point_col = neg_q ? sc_q - col_off : sc_q + col_off;

	assign ady_zero = (ady_q == '0);
	assign div_busy = (div_cnt_q != rslw_pkg::DIV_LAST);
	assign not_last = (cnt_q != CW'(1));

	always_ff @(posedge clk) begin
		if (ctrl.ld) begin
			sc_q      <= sc;
			row_q     <= sr;
			up_q      <= (er >= sr);
			neg_q     <= (ec < sc);
			ady_q     <= (er >= sr) ? er - sr : sr - er;
			cnt_q     <= (er >= sr) ? er - sr : sr - er;
			dvd_q     <= (ec < sc) ? sc - ec : ec - sc;
			rem_q     <= '0;
			div_cnt_q <= '0;
			q_q       <= '0;
			r_q       <= '0;
		end
		if (ctrl.div) begin
			rem_q     <= trial_ge ? CW'(trial - {1'b0, ady_q}) : trial[CW-1:0];
			dvd_q     <= {dvd_q[CW-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (ctrl.emit) begin
			result_q.point_col  <= point_col;
			result_q.point_row  <= row_q;
			result_q.last_point <= !not_last;
			row_q <= up_q ? row_q + 1'b1 : row_q - 1'b1;
			cnt_q <= cnt_q - 1'b1;
			q_q   <= q_sum[CW-1:0];
			r_q   <= wrap ? CW'(r_sum - {1'b0, ady_q}) : r_sum[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctrl.emit;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/row_stepped_line_walker_top.sv =====
// top level of the row stepped line walker: sequencer plus datapath
// depends on rslw_pkg, rslw_seq, rslw_datapath
//
// channel   direction  transfer                       payload
// item      in         start && !busy at clk edge     rslw_pkg::in_item_t
// result    out        result_valid for one cycle     rslw_pkg::out_item_t
//
// one item runs a load step, a check step, the serial divider steps and then one
// emit step per row of |end_row - start_row|; it ends after the check when rows match
// the 5-bit serial divider and the one-point-per-cycle emit step set the run length
// points come out of a register in the cycle after their emit step, back to back
// arst_n clears the step counter and the result strobe; payload is not reset
// the receiver cannot stall: every strobed result counts as transferred
module row_stepped_line_walker_top #(
	parameter int GRID_SIZE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rslw_pkg::in_item_t  item,
	output logic                busy,
	output logic                result_valid,
	output rslw_pkg::out_item_t result
);

	rslw_pkg::ctrl_t ctrl;
	rslw_pkg::stat_t stat;
	logic            ady_zero;
	logic            div_busy;
	logic            not_last;

	// status flags gathered for the jump logic
	assign stat = '{start: start, ady_zero: ady_zero, div_busy: div_busy, not_last: not_last};

	rslw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// operands load every idle cycle; only the one seen with start is used
	rslw_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.item         (item),
		.ady_zero     (ady_zero),
		.div_busy     (div_busy),
		.not_last     (not_last),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/rslw_checker.sv =====
// port level checker for the row stepped line walker, bound to the top level
// depends on rslw_pkg and assert_macros.svh
`include "assert_macros.svh"

module rslw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input rslw_pkg::in_item_t  item,
	input logic                busy,
	input logic                result_valid,
	input rslw_pkg::out_item_t result
);

	`AST_CLK(a_valid_after_busy, clk, arst_n, result_valid |-> $past(busy), "result without run")
	`AST_CLK(a_busy_needs_start, clk, arst_n, $rose(busy) |-> $past(start), "run began without start")
	`AST_CLK(a_run_contiguous, clk, arst_n, (result_valid && !result.last_point) |=> result_valid, "gap inside run")
	`AST_CLK(a_last_ends_run, clk, arst_n, (result_valid && result.last_point) |=> !result_valid, "point after last")

endmodule

bind row_stepped_line_walker_top rslw_checker u_rslw_checker (.*);
